[design/fbvt_pkg.sv]
// constants, field layout and types for the frustum box visibility test unit
// no dependencies; imported by the top level and its checker
package fbvt_pkg;

	localparam int PLANE_COUNT = 6;

	localparam int IDX_W = 3;
	localparam int NRM_W = 16;
	localparam int CRD_W = 24;

	// offset is Q16.8, products are Q.22, so the offset moves up by the normal's fraction
	localparam int OFF_SHIFT = 14;

	localparam int PROD_W = NRM_W + CRD_W;
	localparam int MAGP_W = NRM_W + CRD_W - 1;
	localparam int ACC_W  = 42;

	localparam int S_TDATA_W = 224;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 1;

	localparam int IDX_LSB = 0;
	localparam int A_LSB   = 3;
	localparam int B_LSB   = 19;
	localparam int C_LSB   = 35;
	localparam int D_LSB   = 51;
	localparam int CX_LSB  = 75;
	localparam int CY_LSB  = 99;
	localparam int CZ_LSB  = 123;
	localparam int HX_LSB  = 147;
	localparam int HY_LSB  = 171;
	localparam int HZ_LSB  = 195;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} op_t;

	// n[0] = a, n[1] = b, n[2] = c
	typedef struct packed {
		logic [CRD_W-1:0]      d;
		logic [2:0][NRM_W-1:0] n;
	} plane_t;

endpackage

[design/frustum_box_visibility_test_unit.sv]
// frustum box visibility test unit: six clip planes and a three-stage test pipeline
// depends on fbvt_pkg
//
// input channel s_*: s_tuser selects the operation (0 loads one plane, 1 tests a box),
// s_tdata carries the plane index, normal, offset, box centre and half extents.
// output channel m_*: one word per input word, in order; m_tdata[0] is the visible
// flag, m_tuser is set when the word answers a test and clear for a load acknowledge.
// m_tvalid rises once the word has passed stage 1, stage 2 and the output register; one
// word per cycle is sustained while m_tready is high. the plane registers are written
// as the load word is accepted, so a test accepted in the next cycle sees the new plane.
// stage 1 registers the centre and |half extents|, stage 2 registers the six products
// for every plane, and the output register holds the sign test of the per-plane sums.
// reset clears all planes to zero (a zero plane never culls) and empties the pipeline.
// when m_tready is low the output word holds; earlier stages keep filling, and s_tready
// falls only once all three stages hold a word.
module frustum_box_visibility_test_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// plane_index, plane_a, plane_b, plane_c, plane_d, center_x, center_y, center_z,
	// half_x, half_y, half_z, zero fill
	input  logic [fbvt_pkg::S_TDATA_W-1:0] s_tdata,
	// op
	input  logic [fbvt_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// visible, zero fill
	output logic [fbvt_pkg::M_TDATA_W-1:0] m_tdata,
	// was_test
	output logic [fbvt_pkg::M_TUSER_W-1:0] m_tuser
);
	import fbvt_pkg::*;

	plane_t                planes_q [PLANE_COUNT];

	logic                  valid_s1;
	logic                  test_s1;
	logic [2:0][CRD_W-1:0] ctr_s1;
	logic [2:0][CRD_W-1:0] hmag_s1;

	logic                     valid_s2;
	logic                     test_s2;
	logic signed [PROD_W-1:0] dot_s2 [PLANE_COUNT][3];
	logic        [MAGP_W-1:0] ext_s2 [PLANE_COUNT][3];
	logic        [CRD_W-1:0]  off_s2 [PLANE_COUNT];

	logic signed [PROD_W-1:0] dot_c [PLANE_COUNT][3];
	logic        [MAGP_W-1:0] ext_c [PLANE_COUNT][3];

	logic out_valid_q;
	logic visible_q;
	logic was_test_q;
	logic visible_c;

	logic rdy_out, rdy_s2, rdy_s1;
	logic in_fire;
	op_t  in_op;

	logic [IDX_W-1:0]      in_idx;
	logic [2:0][CRD_W-1:0] in_ctr;
	logic [2:0][CRD_W-1:0] in_half;
	logic [2:0][CRD_W-1:0] in_hmag;
	plane_t                in_plane;

	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s2   = !valid_s2 || rdy_out;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign in_fire  = s_tvalid && rdy_s1;
	assign in_op    = op_t'(s_tuser[0]);

	assign in_idx        = s_tdata[IDX_LSB +: IDX_W];
	assign in_plane.n[0] = s_tdata[A_LSB +: NRM_W];
	assign in_plane.n[1] = s_tdata[B_LSB +: NRM_W];
	assign in_plane.n[2] = s_tdata[C_LSB +: NRM_W];
	assign in_plane.d    = s_tdata[D_LSB +: CRD_W];
	assign in_ctr[0]     = s_tdata[CX_LSB +: CRD_W];
	assign in_ctr[1]     = s_tdata[CY_LSB +: CRD_W];
	assign in_ctr[2]     = s_tdata[CZ_LSB +: CRD_W];
	assign in_half[0]    = s_tdata[HX_LSB +: CRD_W];
	assign in_half[1]    = s_tdata[HY_LSB +: CRD_W];
	assign in_half[2]    = s_tdata[HZ_LSB +: CRD_W];

	// magnitude of the most negative value still fits as unsigned
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_hmag[k] = in_half[k][CRD_W-1] ? CRD_W'(-in_half[k]) : in_half[k];
		end
	end

	// plane store; an index past the last plane matches no entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				planes_q[p] <= '0;
			end
		end else if (in_fire && in_op == OP_LOAD) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				if ((IDX_W+1)'(in_idx) == (IDX_W+1)'(p)) begin
					planes_q[p] <= in_plane;
				end
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// per-plane products: centre dot and |normal| times |half extent|
	always_comb begin
		logic [NRM_W-1:0] amag;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			for (int k = 0; k < 3; k++) begin
				amag = planes_q[p].n[k][NRM_W-1] ? NRM_W'(-planes_q[p].n[k])
				                                 : planes_q[p].n[k];
				dot_c[p][k] = PROD_W'($signed(planes_q[p].n[k])) * PROD_W'($signed(ctr_s1[k]));
				ext_c[p][k] = MAGP_W'(amag) * MAGP_W'(hmag_s1[k]);
			end
		end
	end

	// sum per plane, exact; a negative best corner culls the box
	always_comb begin
		logic signed [ACC_W-1:0] acc;
		logic                    culled;
		culled = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			acc = ACC_W'(dot_s2[p][0]) + ACC_W'(dot_s2[p][1]) + ACC_W'(dot_s2[p][2])
			    + $signed(ACC_W'(ext_s2[p][0])) + $signed(ACC_W'(ext_s2[p][1]))
			    + $signed(ACC_W'(ext_s2[p][2]))
			    + ACC_W'($signed({off_s2[p], {OFF_SHIFT{1'b0}}}));
			if (acc[ACC_W-1]) begin
				culled = 1'b1;
			end
		end
		visible_c = test_s2 && !culled;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			test_s1 <= (in_op == OP_TEST);
			ctr_s1  <= in_ctr;
			hmag_s1 <= in_hmag;
		end
		if (rdy_s2 && valid_s1) begin
			test_s2 <= test_s1;
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int k = 0; k < 3; k++) begin
					dot_s2[p][k] <= dot_c[p][k];
					ext_s2[p][k] <= ext_c[p][k];
				end
				off_s2[p] <= planes_q[p].d;
			end
		end
		if (rdy_out && valid_s2) begin
			visible_q  <= visible_c;
			was_test_q <= test_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, visible_q};
	assign m_tuser  = M_TUSER_W'(was_test_q);

endmodule

[design/fbvt_checker.sv]
// port-level checker for the frustum box visibility test unit, bound to the top level
// depends on fbvt_pkg
module fbvt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [fbvt_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [fbvt_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [fbvt_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [fbvt_pkg::M_TUSER_W-1:0] m_tuser
);
	import fbvt_pkg::*;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// input only backs up once the output is stalled
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	// with the output draining, an accepted word comes out with the op it was sent with
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid && m_tuser == $past(s_tuser, 3))
		else $error("result missing or of the wrong kind after three cycles");

	// a load acknowledge never reports visible
	a_load_not_visible: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == 1'b0 |-> m_tdata[0] == 1'b0)
		else $error("load acknowledge reports visible");

endmodule

bind frustum_box_visibility_test_unit fbvt_checker u_fbvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/sv/frustum_box_visibility_test_unit_checker.sv]
// checker for the frustum box visibility test unit: watches both stream channels,
// keeps its own copy of the clip planes, predicts each output word and compares
// depends on fbvt_pkg; instantiated beside the block by the testbench top
module frustum_box_visibility_test_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// plane_index, plane_a, plane_b, plane_c, plane_d, center_x, center_y, center_z,
	// half_x, half_y, half_z, zero fill
	input  logic [fbvt_pkg::S_TDATA_W-1:0] s_tdata,
	// op
	input  logic [fbvt_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// visible, zero fill
	input  logic [fbvt_pkg::M_TDATA_W-1:0] m_tdata,
	// was_test
	input  logic [fbvt_pkg::M_TUSER_W-1:0] m_tuser,
	output int                             fail_count,
	output int                             pending
);
	import fbvt_pkg::*;

	typedef struct packed {
		logic visible;
		logic was_test;
	} verdict_t;

	plane_t   planes [PLANE_COUNT];
	verdict_t verdict_q [$];

	initial fail_count = 0;

	task automatic report(input string what);
		$display("%0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic void store_plane(input logic [S_TDATA_W-1:0] word);
		logic [IDX_W-1:0] idx;
		idx = word[IDX_LSB +: IDX_W];
		// an index past the last plane is acknowledged but writes nothing
		if (idx < PLANE_COUNT) begin
			for (int k = 0; k < 3; k++)
				planes[idx].n[k] = word[A_LSB + k*NRM_W +: NRM_W];
			planes[idx].d = word[D_LSB +: CRD_W];
		end
	endfunction

	// culled when some plane has its most positive corner still below zero
	function automatic verdict_t judge_box(input logic [S_TDATA_W-1:0] word);
		verdict_t v;
		longint   cen [3];
		longint   hmag [3];
		longint   nrm;
		longint   reach;
		v.was_test = 1'b1;
		v.visible  = 1'b1;
		for (int k = 0; k < 3; k++) begin
			cen[k]  = longint'($signed(word[CX_LSB + k*CRD_W +: CRD_W]));
			hmag[k] = longint'($signed(word[HX_LSB + k*CRD_W +: CRD_W]));
			if (hmag[k] < 0)
				hmag[k] = -hmag[k];
		end
		for (int p = 0; p < PLANE_COUNT; p++) begin
			// offset brought up to the 22 fraction bits of the products
			reach = longint'($signed(planes[p].d)) <<< OFF_SHIFT;
			for (int k = 0; k < 3; k++) begin
				nrm   = longint'($signed(planes[p].n[k]));
				reach += nrm * cen[k] + (nrm < 0 ? -nrm : nrm) * hmag[k];
			end
			if (reach < 0)
				v.visible = 1'b0;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			foreach (planes[p])
				planes[p] = '0;
			verdict_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report("output word with nothing expected");
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want.visible)
						report($sformatf("visible: got %b want %b", m_tdata[0], want.visible));
					if (m_tuser[0] !== want.was_test)
						report($sformatf("was_test: got %b want %b", m_tuser[0], want.was_test));
				end
			end
			// the block writes a plane as the load is taken, so order here is enough
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_TEST) begin
					verdict_q.push_back(judge_box(s_tdata));
				end else begin
					store_plane(s_tdata);
					verdict_q.push_back('{visible: 1'b0, was_test: 1'b0});
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

[tb/sv/frustum_box_visibility_test_unit_test.sv]
// testbench top for the frustum box visibility test unit: clock, reset, plane loads
// and box tests on the input stream, random back-pressure on the output stream
// depends on fbvt_pkg, the block and frustum_box_visibility_test_unit_checker
module frustum_box_visibility_test_unit_test;
	import fbvt_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int mismatches;
	int pending;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit long_hold = 1'b0;

	always #2 clk = ~clk;

	frustum_box_visibility_test_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	frustum_box_visibility_test_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (mismatches),
		.pending    (pending)
	);

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// random fields everywhere; the op in use overwrites its own
	function automatic logic [S_TDATA_W-1:0] noise_word();
		logic [S_TDATA_W-1:0] w;
		for (int k = 0; k < S_TDATA_W / 32; k++)
			w[k*32 +: 32] = $urandom();
		w[S_TDATA_W-1 : HZ_LSB + CRD_W] = '0;
		return w;
	endfunction

	function automatic logic [CRD_W-1:0] rand_coord(input bit near);
		if (near)
			return CRD_W'($urandom_range(0, 131071) - 65536);
		return CRD_W'($urandom());
	endfunction

	task automatic send_word(input op_t op, input logic [S_TDATA_W-1:0] data);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_plane(input logic [IDX_W-1:0] idx, input logic [NRM_W-1:0] a,
			input logic [NRM_W-1:0] b, input logic [NRM_W-1:0] c, input logic [CRD_W-1:0] d);
		logic [S_TDATA_W-1:0] w;
		w = noise_word();
		w[IDX_LSB +: IDX_W] = idx;
		w[A_LSB +: NRM_W]   = a;
		w[B_LSB +: NRM_W]   = b;
		w[C_LSB +: NRM_W]   = c;
		w[D_LSB +: CRD_W]   = d;
		send_word(OP_LOAD, w);
	endtask

	task automatic test_box(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy,
			input logic [CRD_W-1:0] cz, input logic [CRD_W-1:0] hx,
			input logic [CRD_W-1:0] hy, input logic [CRD_W-1:0] hz);
		logic [S_TDATA_W-1:0] w;
		w = noise_word();
		w[CX_LSB +: CRD_W] = cx;
		w[CY_LSB +: CRD_W] = cy;
		w[CZ_LSB +: CRD_W] = cz;
		w[HX_LSB +: CRD_W] = hx;
		w[HY_LSB +: CRD_W] = hy;
		w[HZ_LSB +: CRD_W] = hz;
		send_word(OP_TEST, w);
	endtask

	// output side: a random stall before each word, one long hold-off on request
	initial begin
		int w;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
				long_hold = 1'b0;
			end
			w = rx_calm ? 0 : $urandom_range(0, 19);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		bit               near;
		int               pick;
		logic [CRD_W-1:0] hx, hy, hz;
		logic [NRM_W-1:0] na, nb, nc;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_LOAD;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all planes zero after reset: nothing culls
		test_box(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
			rand_coord(0));
		test_box('0, '0, '0, '0, '0, '0);
		// indexes past the last plane leave the planes alone
		load_plane(3'd6, 16'h4000, '0, '0, 24'h800000);
		load_plane(3'd7, 16'h8000, 16'h8000, 16'h8000, 24'h800000);
		test_box(rand_coord(0), rand_coord(0), rand_coord(0), '0, '0, '0);
		// x >= 0 half space
		load_plane(3'd0, 16'h4000, '0, '0, '0);
		test_box(24'hFFFF00, '0, '0, '0, '0, '0);
		test_box('0, '0, '0, '0, '0, '0);
		// corner exactly on the plane, then one step outside
		test_box(24'hFFFF00, '0, '0, 24'h000100, 24'h000100, 24'h000100);
		test_box(24'hFFFF00, '0, '0, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00);
		test_box(24'hFFFEFF, '0, '0, 24'h000100, 24'h000100, 24'h000100);
		load_plane(3'd5, 16'h8000, 16'h8000, 16'h8000, 24'h7FFFFF);
		test_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0);
		test_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
		test_box(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		load_plane(3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h800000);
		test_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0);
		test_box(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		load_plane(3'd3, '0, '0, 16'hFFFF, 24'h7FFFFF);
		test_box('0, '0, 24'h7FFFFF, '0, '0, '0);
		load_plane(3'd0, '0, '0, '0, '0);
		test_box(24'hFFFF00, '0, '0, '0, '0, '0);
		test_box(rand_coord(1), rand_coord(1), rand_coord(1), 24'h800000, 24'h000001,
			24'hFFFFFF);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int ph = 0; ph < 8; ph++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (ph == 2) begin
				// input keeps coming while the output side is held off
				tx_calm   = 1'b1;
				long_hold = 1'b1;
			end
			// near: planes with the origin well inside, boxes close to it
			near = ($urandom_range(0, 1) == 1);
			for (int p = 0; p < PLANE_COUNT; p++) begin
				na = NRM_W'($urandom());
				nb = NRM_W'($urandom());
				nc = NRM_W'($urandom());
				if ($urandom_range(0, 7) == 0)
					{na, nb, nc} = '0;
				load_plane(IDX_W'(p), na, nb, nc,
					near ? CRD_W'($urandom_range(0, 8388607)) : CRD_W'($urandom()));
			end
			for (int i = 0; i < 55; i++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_word(OP_LOAD, noise_word());
				end else if (pick == 1) begin
					send_word(OP_TEST, noise_word());
				end else begin
					case ($urandom_range(0, 3))
						0: begin
							{hx, hy, hz} = '0;
						end
						1: begin
							hx = rand_coord($urandom_range(0, 1) == 1);
							hy = hx;
							hz = hx;
						end
						2: begin
							hx = rand_coord(0);
							hy = rand_coord(0);
							hz = rand_coord(0);
						end
						default: begin
							hx = rand_coord(1);
							hy = rand_coord(1);
							hz = rand_coord(1);
						end
					endcase
					test_box(rand_coord(near), rand_coord(near), rand_coord(near), hx, hy, hz);
				end
			end
			// let the pipeline drain completely once before going on
			if (ph == 4) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
design/fbvt_pkg.sv
design/frustum_box_visibility_test_unit.sv
design/fbvt_checker.sv
tb/sv/frustum_box_visibility_test_unit_checker.sv
tb/sv/frustum_box_visibility_test_unit_test.sv
